@@ design/ibfr_pkg.sv @@
// Shared types and constants for the i-bus frame receiver.
// Used by the controller, the datapath and the top level; depends on nothing.
package ibfr_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] CHECK_END = POS_W'(30);
	localparam logic [POS_W-1:0] CSUM_LO   = POS_W'(30);
	localparam logic [POS_W-1:0] CSUM_HI   = POS_W'(31);
	localparam logic [POS_W-1:0] CHAN_BASE = POS_W'(2);

	localparam logic [15:0] CSUM_INIT  = 16'hFFFF;
	localparam logic [15:0] GAP_RESET  = 16'd3000;
	localparam logic [7:0]  SYNC_RESET = 8'h20;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_POLL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_GAP  = 1'b0,
		CFG_SYNC = 1'b1
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic do_byte;
		logic poll_start;
		logic sum_issue;
		logic check;
		logic chan_start;
		logic chan_issue;
		logic load_out;
	} ibfr_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic frame_done;
		logic sum_last;
		logic chan_last;
		logic csum_ok;
		logic out_free;
	} ibfr_stat_t;

endpackage

@@ design/ibfr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module ibfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/ibfr_ctrl.sv @@
// Controller state machine of the i-bus frame receiver.
// Depends on ibfr_pkg for the command and status structs.
module ibfr_ctrl import ibfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  ibfr_stat_t stat,
	output ibfr_ctl_t  ctl
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_EXEC   = 8'b0000_0010,
		ST_SUM    = 8'b0000_0100,
		ST_DRAIN  = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_CHAN   = 8'b0010_0000,
		ST_CDRAIN = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.cmd)
					CMD_BYTE: begin
						ctl.do_byte = 1'b1;
						state_d     = ST_DONE;
					end
					CMD_POLL: begin
						// A poll with no finished frame reports pending at once.
						if (stat.frame_done) begin
							ctl.poll_start = 1'b1;
							state_d        = ST_SUM;
						end else begin
							state_d = ST_DONE;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SUM: begin
				ctl.sum_issue = 1'b1;
				if (stat.sum_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_CHECK;
			ST_CHECK: begin
				ctl.check = 1'b1;
				if (stat.csum_ok) begin
					ctl.chan_start = 1'b1;
					state_d        = ST_CHAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CHAN: begin
				ctl.chan_issue = 1'b1;
				if (stat.chan_last) begin
					state_d = ST_CDRAIN;
				end
			end
			ST_CDRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/ibfr_datapath.sv @@
// Datapath of the i-bus frame receiver: input and output registers, frame
// position, checksum sweep and channel store. Depends on ibfr_pkg and ibfr_ram.
module ibfr_datapath import ibfr_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	input  ibfr_ctl_t   ctl,
	output ibfr_stat_t  stat
);

	localparam int CS_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [POS_W-1:0] CHAN_LAST = POS_W'(2 * NUM_CHANNELS + 1);

	// Configuration registers.
	logic [15:0] gap_q;
	logic [7:0]  sync_q;

	// Captured input item.
	cmd_t        cmd_q;
	logic [7:0]  byte_q;
	logic [31:0] time_q;
	logic [2:0]  chan_q;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [31:0]      last_time_q;
	logic             frame_done_q;
	logic [15:0]      store_q [NUM_CHANNELS];

	// Sweep state.
	logic [POS_W-1:0] idx_q;
	logic [POS_W-1:0] rd_idx_s1;
	logic             rd_sum_s1;
	logic             rd_chan_s1;
	logic [15:0]      expect_q;
	logic [15:0]      got_q;
	logic [7:0]       lo_q;
	logic             ok_q;

	logic [23:0]      out_q;
	logic             out_valid_q;

	// Byte reception.
	logic [31:0]      gap;
	logic [POS_W-1:0] pos_eff;
	logic             take;
	logic             ram_we;
	logic [7:0]       rdata;

	logic [POS_W-1:0] chan_off;
	logic [CS_W-1:0]  wr_ch;
	logic [4:0]       rd_ch_ext;
	logic             rd_in_range;
	logic [15:0]      ch_value;
	logic             status_bit;

	assign gap     = time_q - last_time_q;
	assign pos_eff = (gap > {16'b0, gap_q}) ? '0 : pos_q;
	assign take    = !((pos_eff == '0) && (byte_q != sync_q));
	assign ram_we  = ctl.do_byte && take;

	ibfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_eff),
		.wdata(byte_q),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign chan_off    = rd_idx_s1 - CHAN_BASE;
	assign wr_ch       = chan_off[CS_W:1];
	assign rd_ch_ext   = {2'b0, chan_q};
	assign rd_in_range = rd_ch_ext < 5'(NUM_CHANNELS);
	assign ch_value    = (cmd_q == CMD_READ && rd_in_range) ? store_q[rd_ch_ext[CS_W-1:0]]
		: 16'd0;
	assign status_bit  = (cmd_q == CMD_POLL) && ok_q;

	assign stat.cmd        = cmd_q;
	assign stat.frame_done = frame_done_q;
	assign stat.sum_last   = (idx_q == LAST_POS);
	assign stat.chan_last  = (idx_q == CHAN_LAST);
	assign stat.csum_ok    = (expect_q == got_q);
	assign stat.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
			sync_q <= SYNC_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAP:  gap_q <= cfg_data;
				CFG_SYNC: sync_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input item and sweep payload registers.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd_t'(s_tuser);
			byte_q <= s_tdata[7:0];
			time_q <= s_tdata[39:8];
			chan_q <= s_tdata[42:40];
		end
		if (ctl.poll_start) begin
			expect_q <= CSUM_INIT;
		end else if (rd_sum_s1) begin
			if (rd_idx_s1 < CHECK_END) begin
				expect_q <= expect_q - {8'b0, rdata};
			end else if (rd_idx_s1 == CSUM_LO) begin
				got_q[7:0] <= rdata;
			end else if (rd_idx_s1 == CSUM_HI) begin
				got_q[15:8] <= rdata;
			end
		end
		if (rd_chan_s1 && !rd_idx_s1[0]) begin
			lo_q <= rdata;
		end
		if (ctl.load_out) begin
			out_q <= {7'b0, ch_value, status_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			last_time_q  <= '0;
			frame_done_q <= 1'b0;
			idx_q        <= '0;
			rd_idx_s1    <= '0;
			rd_sum_s1    <= 1'b0;
			rd_chan_s1   <= 1'b0;
			ok_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (ctl.do_byte) begin
				last_time_q <= time_q;
				if (!take) begin
					pos_q <= pos_eff;
				end else if (pos_eff == LAST_POS) begin
					pos_q        <= LAST_POS;
					frame_done_q <= 1'b1;
				end else begin
					pos_q <= pos_eff + POS_W'(1);
				end
			end
			if (ctl.poll_start) begin
				frame_done_q <= 1'b0;
				idx_q        <= '0;
			end else if (ctl.chan_start) begin
				idx_q <= CHAN_BASE;
			end else if (ctl.sum_issue || ctl.chan_issue) begin
				idx_q <= idx_q + POS_W'(1);
			end
			rd_idx_s1  <= idx_q;
			rd_sum_s1  <= ctl.sum_issue;
			rd_chan_s1 <= ctl.chan_issue;
			if (ctl.capture) begin
				ok_q <= 1'b0;
			end else if (ctl.check) begin
				ok_q <= stat.csum_ok;
			end
			// The high byte of each channel completes the little-endian word.
			if (rd_chan_s1 && rd_idx_s1[0]) begin
				store_q[wr_ch] <= {rdata, lo_q};
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_byte |-> !rd_sum_s1 && !rd_chan_s1)
		else $error("frame buffer written during a read sweep");

	a_check_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.check |-> $past(rd_sum_s1 && (rd_idx_s1 == CSUM_HI)))
		else $error("checksum compared before the sweep reached the last byte");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || m_tready))
		else $error("result overwrote an untaken result");

	a_poll_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.poll_start |=> !frame_done_q)
		else $error("poll left the done flag set");

endmodule

@@ design/ibus_frame_receiver_core.sv @@
// Flow: a byte, channel read or idle poll gives its result through the output
// register; a poll of a finished frame first sweeps the frame RAM read port one
// byte a cycle for the checksum and, on a good checksum, then sweeps the channel
// bytes. One item is in work at a time; the next is taken as soon as the result
// sits in the output register. Reset clears control state, the channel store and
// the configuration; the frame RAM is not cleared.
module ibus_frame_receiver_core import ibfr_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // rx_byte[7:0], time_us[39:8], channel[42:40]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // frame_status[0], channel_value[16:1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	ibfr_ctl_t  ctl;
	ibfr_stat_t stat;

	assign cfg_ready = 1'b1;

	ibfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	ibfr_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ctl      (ctl),
		.stat     (stat)
	);

endmodule

@@ tb/ibfr_reply_checker.sv @@
// Reply checker for the i-bus frame receiver: follows the input and register transfers,
// keeps its own copy of the decoder state and compares every output transfer in order.
// Depends on ibfr_pkg for the command and register codes and the frame layout.
module ibfr_reply_checker import ibfr_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // rx_byte[7:0], time_us[39:8], channel[42:40]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // frame_status[0], channel_value[16:1]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        status;
		logic [15:0] value;
	} reply_t;

	logic [15:0]      gap_limit = GAP_RESET;
	logic [7:0]       sync_byte = SYNC_RESET;
	logic [7:0]       frame_mem [FRAME_BYTES];
	logic [POS_W-1:0] pos = '0;
	logic [31:0]      last_us = '0;
	logic             done = 1'b0;
	logic [15:0]      chan_latch [NUM_CHANNELS];
	reply_t           replies_due [$];
	int               fail_cnt = 0;
	int               reply_no = 0;

	function automatic void take_byte(input logic [7:0] b, input logic [31:0] now);
		// The gap is measured modulo 2^32, so a wrapped timestamp still gives a small gap.
		if (now - last_us > {16'd0, gap_limit})
			pos = '0;
		last_us = now;
		if (pos == '0 && b != sync_byte)
			return;
		frame_mem[pos] = b;
		if (pos == LAST_POS)
			done = 1'b1;
		else
			pos = pos + 1'b1;
	endfunction

	function automatic logic check_frame();
		logic [15:0] want;
		if (!done)
			return 1'b0;
		done = 1'b0;
		want = CSUM_INIT;
		for (int k = 0; k < int'(CHECK_END); k++)
			want -= frame_mem[k];
		if (want != {frame_mem[CSUM_HI], frame_mem[CSUM_LO]})
			return 1'b0;
		for (int k = 0; k < NUM_CHANNELS; k++)
			chan_latch[k] = {frame_mem[int'(CHAN_BASE) + 2*k + 1], frame_mem[int'(CHAN_BASE) + 2*k]};
		return 1'b1;
	endfunction

	function automatic reply_t decode_item(input cmd_t cmd, input logic [7:0] b,
	                                       input logic [31:0] now, input logic [2:0] ch);
		reply_t r;
		r = '0;
		case (cmd)
			CMD_BYTE: take_byte(b, now);
			CMD_POLL: r.status = check_frame();
			CMD_READ: begin
				if (int'(ch) < NUM_CHANNELS)
					r.value = chan_latch[ch];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want, got;
		if (!arst_n) begin
			gap_limit = GAP_RESET;
			sync_byte = SYNC_RESET;
			pos = '0;
			last_us = '0;
			done = 1'b0;
			for (int k = 0; k < NUM_CHANNELS; k++)
				chan_latch[k] = '0;
			replies_due.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Retire the output transfer first, so that an item accepted on the same
			// edge cannot stand in for a reply that was never due.
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[0];
				got.value  = m_tdata[16:1];
				if (replies_due.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: reply %0d arrived with none due: status %0b value %04h",
						         $realtime, reply_no, got.status, got.value);
					fail_cnt++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status || got.value !== want.value) begin
						if (fail_cnt < 10)
							$display("%0t: reply %0d: expected status %0b value %04h, got status %0b value %04h",
							         $realtime, reply_no, want.status, want.value, got.status, got.value);
						fail_cnt++;
					end
				end
				reply_no++;
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(decode_item(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[39:8],
				                                  s_tdata[42:40]));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GAP)
					gap_limit = cfg_data;
				else
					sync_byte = cfg_data[7:0];
			end
			outstanding <= replies_due.size();
			mismatches <= fail_cnt;
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the i-bus frame receiver testbench: clock, reset, stimulus and the verdict.
// Depends on ibfr_pkg, ibus_frame_receiver_core and ibfr_reply_checker.
module testbench import ibfr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CHANNELS = 8;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 340;
	localparam int TOTAL_ITEMS  = PHASES * PHASE_ITEMS;
	localparam int CALM_ITEMS   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          mismatches;
	int          outstanding;

	logic [15:0] gap_us;
	logic [7:0]  sync_byte;
	logic [31:0] now_us;
	int          sent;
	bit          calm;
	bit          hold_req;

	ibus_frame_receiver_core #(.NUM_CHANNELS(NUM_CHANNELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ibfr_reply_checker #(.NUM_CHANNELS(NUM_CHANNELS)) reply_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advances the byte clock: a gap within the timeout, or one that restarts the frame.
	function automatic logic [31:0] step_time(input bit long_gap);
		logic [31:0] inc;
		if (long_gap) begin
			case ($urandom_range(0, 3))
				0:       inc = {16'd0, gap_us} + 32'd1;
				1:       inc = $urandom_range(32'h1000_0000, 32'hF000_0000);
				default: inc = {16'd0, gap_us} + 32'd1 + $urandom_range(0, 5000);
			endcase
		end else if ($urandom_range(0, 7) == 0) begin
			inc = {16'd0, gap_us};
		end else begin
			inc = $urandom_range(0, gap_us);
		end
		now_us += inc;
		return now_us;
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [7:0] b, input logic [31:0] t,
	                         input logic [2:0] ch);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'd0, ch, t, b};
		do @(posedge clk); while (!s_tready);
		sent++;
		calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off on request, none near the end.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] sum;
		logic [15:0] gap_next;
		logic [7:0]  sync_next;
		int          cut;
		int          stop;
		cmd_t        cmd;

		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_NONE;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_GAP;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		gap_us    = GAP_RESET;
		sync_byte = SYNC_RESET;
		now_us    = '0;
		sent      = 0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset values, the unused command, an idle poll and the gap edges.
		send_item(CMD_READ, 8'h00, 32'h0, 3'd0);
		send_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		send_item(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		send_item(CMD_POLL, 8'h00, 32'h0, 3'd0);
		// The timestamp wraps between these two bytes, leaving a gap of three.
		send_item(CMD_BYTE, 8'h00, 32'hFFFF_FFFF, 3'd0);
		send_item(CMD_BYTE, SYNC_RESET, 32'd2, 3'd0);
		// A gap equal to the timeout keeps the frame; one more microsecond restarts it.
		send_item(CMD_BYTE, 8'hFF, 32'd2 + GAP_RESET, 3'd7);
		send_item(CMD_BYTE, SYNC_RESET, 32'd3 + GAP_RESET + GAP_RESET, 3'd0);
		send_item(CMD_BYTE, 8'h00, 32'd3 + GAP_RESET + GAP_RESET, 3'd0);
		send_item(CMD_NONE, 8'h00, 32'h0, 3'd0);
		send_item(CMD_READ, 8'h00, 32'h0, 3'd3);
		send_item(CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		now_us = 32'd3 + GAP_RESET + GAP_RESET;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
				repeat (4) @(posedge clk);
				case (ph)
					1: begin gap_next = 16'd0;    sync_next = 8'h00; end
					2: begin gap_next = 16'hFFFF; sync_next = 8'hFF; end
					3: begin gap_next = 16'($urandom_range(1, 4000)); sync_next = 8'($urandom); end
					default: begin gap_next = GAP_RESET; sync_next = SYNC_RESET; end
				endcase
				write_reg(CFG_GAP, gap_next);
				write_reg(CFG_SYNC, {8'd0, sync_next});
				gap_us    = gap_next;
				sync_byte = sync_next;
			end
			// Halfway through, the receiver holds off while items keep coming.
			if (ph == 2)
				hold_req = 1'b1;
			stop = sent + PHASE_ITEMS;
			while (sent < stop) begin
				if ($urandom_range(0, 99) < 75) begin
					// A frame with a good checksum, sometimes spoilt by one flipped bit
					// or cut short by a gap somewhere inside it.
					cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : 0;
					fb[0] = sync_byte;
					sum = CSUM_INIT - sync_byte;
					for (int k = 1; k < int'(CHECK_END); k++) begin
						fb[k] = 8'($urandom);
						sum -= fb[k];
					end
					fb[CSUM_LO] = sum[7:0];
					fb[CSUM_HI] = sum[15:8];
					if ($urandom_range(0, 4) == 0)
						fb[$urandom_range(0, FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(0, 7));
					if ($urandom_range(0, 5) == 0)
						send_item(CMD_BYTE, 8'($urandom), step_time(1'b1), 3'($urandom));
					for (int k = 0; k < FRAME_BYTES; k++)
						send_item(CMD_BYTE, fb[k], step_time(k == 0 || k == cut), 3'($urandom));
					// Bytes past the end overwrite the last checksum byte.
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 3))
							send_item(CMD_BYTE, $urandom_range(0, 1) ? fb[CSUM_HI] : 8'($urandom),
							          step_time(1'b0), 3'($urandom));
					if ($urandom_range(0, 9) != 0)
						send_item(CMD_POLL, 8'($urandom), $urandom, 3'($urandom));
					repeat ($urandom_range(0, 4))
						send_item(CMD_READ, 8'($urandom), $urandom, 3'($urandom));
					if ($urandom_range(0, 5) == 0)
						send_item(CMD_POLL, 8'($urandom), $urandom, 3'($urandom));
				end else begin
					repeat ($urandom_range(1, 8)) begin
						cmd = cmd_t'($urandom_range(0, 3));
						send_item(cmd, 8'($urandom),
						          (cmd == CMD_BYTE) ? step_time(1'($urandom_range(0, 1)))
						                            : $urandom,
						          3'($urandom));
					end
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/ibfr_pkg.sv
design/ibfr_ram.sv
design/ibfr_ctrl.sv
design/ibfr_datapath.sv
design/ibus_frame_receiver_core.sv
tb/ibfr_reply_checker.sv
tb/testbench.sv
